// File: rtl/pcd_pkg.sv
`timescale 1ns / 1ps

package pcd_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] NINE_CHAR  = 8'h39;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_F    = 8'h66;
	localparam logic [7:0] UPPER_A    = 8'h41;
	localparam logic [7:0] UPPER_F    = 8'h46;

	localparam int unsigned MaxResults = 3;

	typedef enum logic [1:0] {
		HOLD_NONE  = 2'd0,
		HOLD_PCT   = 2'd1,
		HOLD_DIGIT = 2'd2
	} hold_state_t;

	// one input's worth of decoded bytes, data[0] goes out first
	typedef struct packed {
		logic [MaxResults-1:0][7:0] data;
		logic [1:0]                 count;
		logic                       last;
	} group_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
			r = {1'b1, 4'(b - ZERO_CHAR)};
		end else if (b >= LOWER_A && b <= LOWER_F) begin
			r = {1'b1, 4'(b - LOWER_A + 8'd10)};
		end else if (b >= UPPER_A && b <= UPPER_F) begin
			r = {1'b1, 4'(b - UPPER_A + 8'd10)};
		end
		return r;
	endfunction

endpackage

// File: rtl/pcd_front.sv
`timescale 1ns / 1ps

module pcd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              grp_push,
	output pcd_pkg::group_t   grp
);

	pcd_pkg::hold_state_t state_q;
	pcd_pkg::hold_state_t state_d;
	logic [7:0]           digit_q;
	logic                 accept;
	logic [4:0]           hex_in;
	logic [3:0]           hex_held;
	logic                 is_hex;
	logic                 fresh_emit;
	logic [7:0]           fresh_byte;
	logic                 starts_escape;

	assign accept        = push & ~full;
	assign hex_in        = pcd_pkg::hex_decode(in_byte);
	assign hex_held      = 4'(pcd_pkg::hex_decode(digit_q));
	assign is_hex        = hex_in[4];
	assign starts_escape = (in_byte == pcd_pkg::PCT_CHAR) && !in_last;
	assign fresh_emit    = !starts_escape;

	always_comb begin
		if (in_byte == pcd_pkg::PLUS_CHAR) begin
			fresh_byte = pcd_pkg::SPACE_CHAR;
		end else begin
			fresh_byte = in_byte;
		end
	end

	// next state
	always_comb begin
		state_d = pcd_pkg::HOLD_NONE;
		unique case (state_q)
			pcd_pkg::HOLD_NONE: begin
				if (starts_escape) state_d = pcd_pkg::HOLD_PCT;
			end
			pcd_pkg::HOLD_PCT: begin
				if (is_hex && !in_last) state_d = pcd_pkg::HOLD_DIGIT;
				else if (!is_hex && starts_escape) state_d = pcd_pkg::HOLD_PCT;
			end
			pcd_pkg::HOLD_DIGIT: begin
				if (!is_hex && starts_escape) state_d = pcd_pkg::HOLD_PCT;
			end
			default: begin
				if (starts_escape) state_d = pcd_pkg::HOLD_PCT;
			end
		endcase
	end

	// decoded bytes for this transaction
	always_comb begin
		grp.data  = '0;
		grp.count = 2'd0;
		grp.last  = in_last;
		unique case (state_q)
			pcd_pkg::HOLD_PCT: begin
				if (is_hex) begin
					if (in_last) begin
						grp.data[0] = pcd_pkg::PCT_CHAR;
						grp.data[1] = in_byte;
						grp.count   = 2'd2;
					end
				end else begin
					grp.data[0] = pcd_pkg::PCT_CHAR;
					grp.data[1] = fresh_byte;
					grp.count   = fresh_emit ? 2'd2 : 2'd1;
				end
			end
			pcd_pkg::HOLD_DIGIT: begin
				if (is_hex) begin
					grp.data[0] = {hex_held, hex_in[3:0]};
					grp.count   = 2'd1;
				end else begin
					grp.data[0] = pcd_pkg::PCT_CHAR;
					grp.data[1] = digit_q;
					grp.data[2] = fresh_byte;
					grp.count   = fresh_emit ? 2'd3 : 2'd2;
				end
			end
			default: begin
				grp.data[0] = fresh_byte;
				grp.count   = fresh_emit ? 2'd1 : 2'd0;
			end
		endcase
	end

	assign grp_push = accept && (grp.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcd_pkg::HOLD_NONE;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (accept && state_q == pcd_pkg::HOLD_PCT && is_hex && !in_last) begin
			digit_q <= in_byte;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (state_q == pcd_pkg::HOLD_NONE))
		else $error("escape still held after end of string");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |-> grp_push)
		else $error("end of string produced no output");

endmodule

// File: rtl/pcd_fifo.sv
`timescale 1ns / 1ps

module pcd_fifo #(
	parameter int unsigned Depth = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  pcd_pkg::group_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output pcd_pkg::group_t rd_data,
	output logic            empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	pcd_pkg::group_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> !full)
		else $error("queue write while full");

	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> !empty)
		else $error("queue read while empty");

endmodule

// File: rtl/pcd_back.sv
`timescale 1ns / 1ps

module pcd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pcd_pkg::group_t head,
	input  logic            head_empty,
	output logic            head_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      out_byte,
	output logic            run_end,
	output logic            string_end
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       final_one;

	assign load      = !head_empty && (!valid_q || pop);
	assign final_one = (idx_q == head.count - 2'd1);
	assign head_pop  = load && final_one;
	assign empty     = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_one ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte   <= head.data[idx_q];
			run_end    <= final_one;
			string_end <= final_one && head.last;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!head_empty |-> (head.count != 2'd0) && (idx_q < head.count))
		else $error("byte index outside queued group");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && string_end) |-> run_end)
		else $error("string end without run end");

endmodule

// File: rtl/percent_decode_stream.sv
// channel   direction  handshake             payload
// input     in         push / full           in_byte, in_last
// result    out        empty / pop           out_byte, run_end, string_end
//
// the front decodes an input byte; its results pass through the queue into
// the result register. one input is taken every cycle while the queue has
// room. the result register drains one byte per cycle while the receiver
// pops, so an input that gives two or three bytes holds the back end longer
// and the queue of QUEUE_DEPTH groups absorbs it. arst_n empties the queue
// and drops any held escape. full rises only when the queue is full.
`timescale 1ns / 1ps

module percent_decode_stream #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_end
);

	pcd_pkg::group_t grp;
	pcd_pkg::group_t head;
	logic            grp_push;
	logic            head_pop;
	logic            head_empty;

	pcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.grp_push (grp_push),
		.grp      (grp)
	);

	pcd_fifo #(
		.Depth (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (grp_push),
		.wr_data (grp),
		.full    (full),
		.rd_en   (head_pop),
		.rd_data (head),
		.empty   (head_empty)
	);

	pcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule

// File: tb/percent_decode_stream_tb.sv
`timescale 1ns / 1ps

module percent_decode_stream_tb;
	import pcd_pkg::*;

	localparam int unsigned RandItems = 400;
	localparam int unsigned IdleLimit = 2000;
	localparam int unsigned TailCycles = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       drain;
	} raw_byte_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       string_end;
	} dec_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       run_end;
	logic       string_end;

	raw_byte_t   encoded_q[$];
	dec_byte_t   decoded_q[$];
	hold_state_t hold = HOLD_NONE;
	logic [7:0]  held_digit = 8'h00;

	int unsigned total_bytes = 0;
	int unsigned sent_bytes = 0;
	int unsigned mismatches = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	bit          send_quiet = 1'b0;
	bit          recv_quiet = 1'b0;
	int unsigned idle_cycles = 0;

	percent_decode_stream uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.run_end   (run_end),
		.string_end(string_end)
	);

	always #6 clk = ~clk;

	function automatic bit is_hex(input logic [7:0] b);
		return (b >= ZERO_CHAR && b <= NINE_CHAR) || (b >= LOWER_A && b <= LOWER_F) ||
			(b >= UPPER_A && b <= UPPER_F);
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] b);
		logic [7:0] v;
		if (b >= LOWER_A) begin
			v = b - LOWER_A + 8'd10;
		end else if (b >= UPPER_A) begin
			v = b - UPPER_A + 8'd10;
		end else begin
			v = b - ZERO_CHAR;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] pick_hex();
		int unsigned r;
		r = $urandom_range(0, 21);
		if (r < 10) begin
			return ZERO_CHAR + 8'(r);
		end else if (r < 16) begin
			return LOWER_A + 8'(r - 10);
		end
		return UPPER_A + 8'(r - 16);
	endfunction

	// works out the decoded bytes for one accepted input byte
	function automatic void decode_byte(input logic [7:0] b, input logic last);
		logic [7:0]  res[3];
		int          n;
		bit          fresh;
		hold_state_t st;
		dec_byte_t   d;
		n = 0;
		fresh = 1'b0;
		st = hold;
		hold = HOLD_NONE;
		case (st)
			HOLD_PCT: begin
				if (is_hex(b)) begin
					if (last) begin
						res[0] = PCT_CHAR;
						res[1] = b;
						n = 2;
					end else begin
						hold = HOLD_DIGIT;
						held_digit = b;
					end
				end else begin
					res[0] = PCT_CHAR;
					n = 1;
					fresh = 1'b1;
				end
			end
			HOLD_DIGIT: begin
				if (is_hex(b)) begin
					res[0] = {nibble_of(held_digit), nibble_of(b)};
					n = 1;
				end else begin
					res[0] = PCT_CHAR;
					res[1] = held_digit;
					n = 2;
					fresh = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if (b == PCT_CHAR && !last) begin
				hold = HOLD_PCT;
			end else begin
				res[n] = (b == PLUS_CHAR) ? SPACE_CHAR : b;
				n++;
			end
		end
		for (int k = 0; k < n; k++) begin
			d.data = res[k];
			d.run_end = (k == n - 1);
			d.string_end = (k == n - 1) && last;
			decoded_q.push_back(d);
		end
	endfunction

	function automatic void add_string(input string s, input bit last_on_end);
		raw_byte_t r;
		for (int i = 0; i < s.len(); i++) begin
			r.data = s[i];
			r.last = last_on_end && (i == s.len() - 1);
			r.drain = 1'b0;
			encoded_q.push_back(r);
		end
	endfunction

	function automatic void add_byte(input logic [7:0] b, input logic last, input logic drain);
		raw_byte_t r;
		r.data = b;
		r.last = last;
		r.drain = drain;
		encoded_q.push_back(r);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic      nxt_push;
		raw_byte_t r;
		if (!arst_n) begin
			push <= 1'b0;
			in_byte <= 8'h00;
			in_last <= 1'b0;
			send_gap = 0;
		end else begin
			nxt_push = push;
			if (push && !full) begin
				decode_byte(in_byte, in_last);
				sent_bytes++;
				nxt_push = 1'b0;
				if ($urandom_range(0, 15) == 0) begin
					send_quiet = !send_quiet;
				end
				send_gap = send_quiet ? 0 : $urandom_range(0, 7);
			end
			if (!nxt_push) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (encoded_q.size() > 0 &&
						!(encoded_q[0].drain && decoded_q.size() != 0)) begin
					r = encoded_q.pop_front();
					in_byte <= r.data;
					in_last <= r.last;
					nxt_push = 1'b1;
				end
			end
			push <= nxt_push;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : watch_proc
		logic      nxt_pop;
		dec_byte_t d;
		if (!arst_n) begin
			pop <= 1'b0;
			recv_gap = 0;
		end else begin
			nxt_pop = pop;
			if (pop && !empty) begin
				if (decoded_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected transaction: out_byte=%h run_end=%b string_end=%b",
							out_byte, run_end, string_end);
					end
				end else begin
					d = decoded_q.pop_front();
					if (out_byte !== d.data || run_end !== d.run_end ||
							string_end !== d.string_end) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected %h/%b/%b got %h/%b/%b",
								d.data, d.run_end, d.string_end,
								out_byte, run_end, string_end);
						end
					end
				end
				nxt_pop = 1'b0;
				if ($urandom_range(0, 15) == 0) begin
					recv_quiet = !recv_quiet;
				end
				recv_gap = recv_quiet ? 0 : $urandom_range(0, 7);
			end
			if (!nxt_pop) begin
				if (recv_gap > 0) begin
					recv_gap--;
				end else begin
					nxt_pop = 1'b1;
				end
			end
			pop <= nxt_pop;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IdleLimit) begin
				$display("percent_decode_stream regression: fail");
				$finish;
			end
		end
	end

	initial begin : stim_proc
		logic [7:0]  str[$];
		int unsigned len;
		int unsigned w;
		int unsigned n_str;
		// directed strings
		add_string("%4a+", 1'b1);
		add_string("%FF%00", 1'b1);
		add_string("%G%4+%%", 1'b1);
		add_string("%", 1'b1);
		add_string("%7", 1'b1);
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'h00, 1'b1, 1'b0);
		// random strings, mostly well-formed escapes
		n_str = 0;
		while (encoded_q.size() < 22 + RandItems) begin
			str.delete();
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			while (str.size() < len) begin
				w = $urandom_range(0, 99);
				if (w < 45) begin
					str.push_back(PCT_CHAR);
					str.push_back(pick_hex());
					str.push_back(pick_hex());
				end else if (w < 55) begin
					str.push_back(PLUS_CHAR);
				end else if (w < 75) begin
					str.push_back(8'($urandom_range(0, 255)));
				end else if (w < 88) begin
					str.push_back(PCT_CHAR);
				end else begin
					str.push_back(pick_hex());
				end
			end
			for (int i = 0; i < str.size(); i++) begin
				add_byte(str[i], i == str.size() - 1, i == 0 && (n_str % 15) == 7);
			end
			n_str++;
		end
		total_bytes = encoded_q.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent_bytes == total_bytes);
		wait (decoded_q.size() == 0);
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("percent_decode_stream regression: pass");
		end else begin
			$display("percent_decode_stream regression: fail");
		end
		$finish;
	end

endmodule
